FILE: src/ela_pkg.sv
// ----------------------------------------------------------------------------
// ela_pkg
// Shared types, datapath widths and arctangent constants for the look-angle
// CORDIC pipeline.
// ----------------------------------------------------------------------------
package ela_pkg;

	// Datapath word: scaled differences stay below 2^60, CORDIC growth included.
	localparam int DATA_W = 62;
	// Angle accumulator, Q32 radians; magnitudes stay below 2^34.
	localparam int Z_W = 36;
	// Scaled differences are aligned so that their top sits at this bit.
	localparam int GUARD_TOP = 58;
	// Upper limit on the stage count; the arctangent table holds entries 0 to 32.
	localparam int MAX_STAGES = 40;

	// Gain correction: magnitude times INV_GAIN_Q30 / 2^GAIN_FRAC, floored.
	localparam int GAIN_FRAC = 30;
	localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q30 = 30'd652032874;

	localparam longint PI_Q32 = 64'sd13493037704;
	localparam longint HALF_PI_Q32 = 64'sd6746518852;

	// Control that travels alongside each item through the pipeline.
	typedef struct packed {
		logic valid;  // an item occupies this stage
		logic live;   // the vector is nonzero, so the angle is meaningful
	} ctl_t;

	// round(atan(2^-i) * 2^32)
	function automatic logic signed [Z_W-1:0] atan_q32(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = 36'sd3373259426;
			1:  a = 36'sd1991351318;
			2:  a = 36'sd1052175346;
			3:  a = 36'sd534100635;
			4:  a = 36'sd268086748;
			5:  a = 36'sd134174063;
			6:  a = 36'sd67103403;
			7:  a = 36'sd33553749;
			8:  a = 36'sd16777131;
			9:  a = 36'sd8388597;
			10: a = 36'sd4194303;
			11: a = 36'sd2097152;
			12: a = 36'sd1048576;
			13: a = 36'sd524288;
			14: a = 36'sd262144;
			15: a = 36'sd131072;
			16: a = 36'sd65536;
			17: a = 36'sd32768;
			18: a = 36'sd16384;
			19: a = 36'sd8192;
			20: a = 36'sd4096;
			21: a = 36'sd2048;
			22: a = 36'sd1024;
			23: a = 36'sd512;
			24: a = 36'sd256;
			25: a = 36'sd128;
			26: a = 36'sd64;
			27: a = 36'sd32;
			28: a = 36'sd16;
			29: a = 36'sd8;
			30: a = 36'sd4;
			31: a = 36'sd2;
			32: a = 36'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: src/ela_cordic_cell.sv
// ----------------------------------------------------------------------------
// ela_cordic_cell
// One vectoring micro-rotation with a fixed shift, registered at its output.
// ----------------------------------------------------------------------------
module ela_cordic_cell #(
	parameter int SHIFT  = 0,
	parameter int SIDE_W = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ela_pkg::ctl_t                        ctl_in,
	input  logic signed [ela_pkg::DATA_W-1:0]    x_in,
	input  logic signed [ela_pkg::DATA_W-1:0]    y_in,
	input  logic signed [ela_pkg::Z_W-1:0]       z_in,
	input  logic [SIDE_W-1:0]                    side_in,
	output ela_pkg::ctl_t                        ctl_out,
	output logic signed [ela_pkg::DATA_W-1:0]    x_out,
	output logic signed [ela_pkg::DATA_W-1:0]    y_out,
	output logic signed [ela_pkg::Z_W-1:0]       z_out,
	output logic [SIDE_W-1:0]                    side_out
);
	import ela_pkg::*;

	localparam logic signed [Z_W-1:0] ANG = atan_q32(SHIFT);

	logic signed [DATA_W-1:0] xs, ys, x_n, y_n;
	logic signed [Z_W-1:0]    z_n;
	ctl_t                     ctl_q;
	logic signed [DATA_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [SIDE_W-1:0]        side_q;

	// Arithmetic shifts round toward minus infinity.
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_comb begin
		if (!y_in[DATA_W-1]) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + ANG;
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_n;
		y_q    <= y_n;
		z_q    <= z_n;
		side_q <= side_in;
	end

	assign ctl_out  = ctl_q;
	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign side_out = side_q;

endmodule

FILE: src/ela_vec_pass.sv
// ----------------------------------------------------------------------------
// ela_vec_pass
// Full CORDIC vectoring pass: quadrant pre-rotation register followed by a
// chain of micro-rotation cells. Items not live leave with angle and magnitude 0.
// ----------------------------------------------------------------------------
module ela_vec_pass #(
	parameter int STAGES = 30,
	parameter int SIDE_W = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ela_pkg::ctl_t                        ctl_in,
	input  logic signed [ela_pkg::DATA_W-1:0]    x_in,
	input  logic signed [ela_pkg::DATA_W-1:0]    y_in,
	input  logic [SIDE_W-1:0]                    side_in,
	output ela_pkg::ctl_t                        ctl_out,
	output logic signed [ela_pkg::DATA_W-1:0]    mag_out,
	output logic signed [ela_pkg::Z_W-1:0]       angle_out,
	output logic [SIDE_W-1:0]                    side_out
);
	import ela_pkg::*;

	localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(HALF_PI_Q32);

	ctl_t                     ctl_c  [0:STAGES];
	logic signed [DATA_W-1:0] x_c    [0:STAGES];
	logic signed [DATA_W-1:0] y_c    [0:STAGES];
	logic signed [Z_W-1:0]    z_c    [0:STAGES];
	logic [SIDE_W-1:0]        side_c [0:STAGES];

	logic signed [DATA_W-1:0] x_pre, y_pre;
	logic signed [Z_W-1:0]    z_pre;
	ctl_t                     ctl_q;
	logic signed [DATA_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [SIDE_W-1:0]        side_q;

	// Vectors in the left half plane are turned by a quarter turn first.
	always_comb begin
		if (x_in[DATA_W-1]) begin
			if (!y_in[DATA_W-1]) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = HALF_PI;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -HALF_PI;
			end
		end else begin
			x_pre = x_in;
			y_pre = y_in;
			z_pre = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_pre;
		y_q    <= y_pre;
		z_q    <= z_pre;
		side_q <= side_in;
	end

	assign ctl_c[0]  = ctl_q;
	assign x_c[0]    = x_q;
	assign y_c[0]    = y_q;
	assign z_c[0]    = z_q;
	assign side_c[0] = side_q;

	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		ela_cordic_cell #(
			.SHIFT  (g),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[g]),
			.x_in     (x_c[g]),
			.y_in     (y_c[g]),
			.z_in     (z_c[g]),
			.side_in  (side_c[g]),
			.ctl_out  (ctl_c[g+1]),
			.x_out    (x_c[g+1]),
			.y_out    (y_c[g+1]),
			.z_out    (z_c[g+1]),
			.side_out (side_c[g+1])
		);
	end

	assign ctl_out   = ctl_c[STAGES];
	assign mag_out   = ctl_c[STAGES].live ? x_c[STAGES] : '0;
	assign angle_out = ctl_c[STAGES].live ? z_c[STAGES] : '0;
	assign side_out  = side_c[STAGES];

endmodule

FILE: src/ela_gain.sv
// ----------------------------------------------------------------------------
// ela_gain
// Two-stage CORDIC gain correction: floor(mag * 1/K), negative taken as 0.
// The product is split into 31-bit and 30-bit parts so no multiplier is wide.
// ----------------------------------------------------------------------------
module ela_gain #(
	parameter int SIDE_W = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ela_pkg::ctl_t                        ctl_in,
	input  logic signed [ela_pkg::DATA_W-1:0]    mag_in,
	input  logic [SIDE_W-1:0]                    side_in,
	output ela_pkg::ctl_t                        ctl_out,
	output logic signed [ela_pkg::DATA_W-1:0]    h_out,
	output logic [SIDE_W-1:0]                    side_out
);
	import ela_pkg::*;

	localparam int HI_W = DATA_W - 1 - GAIN_FRAC;

	logic [DATA_W-2:0]           u;
	ctl_t                        ctl_s1, ctl_s2;
	logic [HI_W+GAIN_FRAC-1:0]   p_hi_s1;
	logic [2*GAIN_FRAC-1:0]      p_lo_s1;
	logic [SIDE_W-1:0]           side_s1, side_s2;
	logic signed [DATA_W-1:0]    h_s2;

	assign u = mag_in[DATA_W-1] ? '0 : mag_in[DATA_W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_hi_s1 <= u[DATA_W-2:GAIN_FRAC] * INV_GAIN_Q30;
		p_lo_s1 <= u[GAIN_FRAC-1:0] * INV_GAIN_Q30;
		side_s1 <= side_in;
		h_s2    <= DATA_W'(p_hi_s1 + (HI_W+GAIN_FRAC)'(p_lo_s1 >> GAIN_FRAC));
		side_s2 <= side_s1;
	end

	assign ctl_out  = ctl_s2;
	assign h_out    = h_s2;
	assign side_out = side_s2;

endmodule

FILE: src/enu_look_angles.sv
// ----------------------------------------------------------------------------
// enu_look_angles
// Azimuth and elevation from an observer to a target in local ENU millimetres,
// computed by two chained CORDIC vectoring pipelines.
// ----------------------------------------------------------------------------
// A start transfer reaches done through the difference register, pass one, the
// gain correction, pass two and the output register.
// Throughput: one transfer per cycle; every micro-rotation is its own cell.
// busy is tied low, since the pipeline never stalls and done cannot be held.
// Reset clears only the control flags (valid, live) and done; no result is lost
// or invented as long as reset is not asserted while items are in flight.
module enu_look_angles #(
	parameter int COORD_WIDTH     = 40,
	parameter int ANGLE_FRAC_BITS = 28,
	parameter int CORDIC_STAGES   = 30
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_WIDTH-1:0]    observer_east,
	input  logic signed [COORD_WIDTH-1:0]    observer_north,
	input  logic signed [COORD_WIDTH-1:0]    observer_up,
	input  logic signed [COORD_WIDTH-1:0]    target_east,
	input  logic signed [COORD_WIDTH-1:0]    target_north,
	input  logic signed [COORD_WIDTH-1:0]    target_up,
	output logic                             done,
	output logic signed [ANGLE_FRAC_BITS+2:0] azimuth,
	output logic signed [ANGLE_FRAC_BITS+1:0] elevation
);
	import ela_pkg::*;

	// Capped at MAX_STAGES; stages past the arctangent table add nothing to the angle.
	localparam int NSTG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	// Differences are shifted up so the datapath keeps the same headroom at
	// every coordinate width.
	localparam int GUARD_BITS = GUARD_TOP - COORD_WIDTH;
	localparam int AZ_W = ANGLE_FRAC_BITS + 3;
	localparam int EL_W = ANGLE_FRAC_BITS + 2;
	// Final rounding from Q32 to the output scale: add half an LSB, shift.
	localparam int SH = 32 - ANGLE_FRAC_BITS;
	localparam longint HALF = 64'sd1 <<< (SH - 1);
	localparam logic signed [Z_W-1:0] RND = Z_W'(HALF);
	localparam logic signed [Z_W-1:0] AZ_LIM = Z_W'((PI_Q32 + HALF) >>> SH);
	localparam logic signed [Z_W-1:0] EL_LIM = Z_W'((HALF_PI_Q32 + HALF) >>> SH);

	// ---------------------------------------------------------------
	// Stage 1: exact differences, target minus observer, then scaled.
	// ---------------------------------------------------------------
	logic signed [COORD_WIDTH:0] d_e, d_n, d_u;
	ctl_t                        ctl_s1;
	logic signed [DATA_W-1:0]    de_s1, dn_s1, du_s1;
	ctl_t                        p1_ctl_in;

	assign busy = 1'b0;

	assign d_e = $signed({target_east[COORD_WIDTH-1], target_east})
		- $signed({observer_east[COORD_WIDTH-1], observer_east});
	assign d_n = $signed({target_north[COORD_WIDTH-1], target_north})
		- $signed({observer_north[COORD_WIDTH-1], observer_north});
	assign d_u = $signed({target_up[COORD_WIDTH-1], target_up})
		- $signed({observer_up[COORD_WIDTH-1], observer_up});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start & ~busy;
			ctl_s1.live  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		de_s1 <= DATA_W'(d_e) <<< GUARD_BITS;
		dn_s1 <= DATA_W'(d_n) <<< GUARD_BITS;
		du_s1 <= DATA_W'(d_u) <<< GUARD_BITS;
	end

	// The azimuth is only meaningful when the horizontal offset is nonzero.
	assign p1_ctl_in.valid = ctl_s1.valid;
	assign p1_ctl_in.live  = (de_s1 != '0) || (dn_s1 != '0);

	// ---------------------------------------------------------------
	// Pass one: vectoring on (north, east) gives the azimuth and the raw
	// horizontal magnitude. The up offset rides along unchanged.
	// ---------------------------------------------------------------
	ctl_t                     p1_ctl;
	logic signed [DATA_W-1:0] p1_mag;
	logic signed [Z_W-1:0]    p1_az;
	logic [DATA_W-1:0]        p1_du;

	ela_vec_pass #(
		.STAGES (NSTG),
		.SIDE_W (DATA_W)
	) u_pass_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (p1_ctl_in),
		.x_in      (dn_s1),
		.y_in      (de_s1),
		.side_in   (du_s1),
		.ctl_out   (p1_ctl),
		.mag_out   (p1_mag),
		.angle_out (p1_az),
		.side_out  (p1_du)
	);

	// ---------------------------------------------------------------
	// Gain correction of the horizontal magnitude; azimuth and up offset
	// travel with it.
	// ---------------------------------------------------------------
	ctl_t                     g_ctl;
	logic signed [DATA_W-1:0] g_h;
	logic [Z_W+DATA_W-1:0]    g_side;
	logic signed [Z_W-1:0]    g_az;
	logic signed [DATA_W-1:0] g_du;
	ctl_t                     p2_ctl_in;

	ela_gain #(
		.SIDE_W (Z_W + DATA_W)
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (p1_ctl),
		.mag_in   (p1_mag),
		.side_in  ({p1_az, p1_du}),
		.ctl_out  (g_ctl),
		.h_out    (g_h),
		.side_out (g_side)
	);

	assign g_az = g_side[Z_W+DATA_W-1:DATA_W];
	assign g_du = g_side[DATA_W-1:0];

	// The elevation is zero when both the horizontal and the up part vanish.
	assign p2_ctl_in.valid = g_ctl.valid;
	assign p2_ctl_in.live  = (g_h != '0) || (g_du != '0);

	// ---------------------------------------------------------------
	// Pass two: vectoring on (horizontal, up) gives the elevation.
	// ---------------------------------------------------------------
	ctl_t                     p2_ctl;
	logic signed [DATA_W-1:0] p2_mag;
	logic signed [Z_W-1:0]    p2_el;
	logic [Z_W-1:0]           p2_az;

	ela_vec_pass #(
		.STAGES (NSTG),
		.SIDE_W (Z_W)
	) u_pass_el (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (p2_ctl_in),
		.x_in      (g_h),
		.y_in      (g_du),
		.side_in   (g_az),
		.ctl_out   (p2_ctl),
		.mag_out   (p2_mag),
		.angle_out (p2_el),
		.side_out  (p2_az)
	);

	// ---------------------------------------------------------------
	// Output stage: round both angles to the output scale and clamp any
	// CORDIC overshoot to plus or minus pi (azimuth) and pi/2 (elevation).
	// The magnitude of the second pass is not needed.
	// ---------------------------------------------------------------
	logic signed [Z_W-1:0] az_r, el_r, az_c, el_c;
	logic                  mag_unused;

	assign mag_unused = ^p2_mag;

	assign az_r = ($signed(p2_az) + RND) >>> SH;
	assign el_r = (p2_el + RND) >>> SH;

	always_comb begin
		if (az_r > AZ_LIM) begin
			az_c = AZ_LIM;
		end else if (az_r < -AZ_LIM) begin
			az_c = -AZ_LIM;
		end else begin
			az_c = az_r;
		end
		if (el_r > EL_LIM) begin
			el_c = EL_LIM;
		end else if (el_r < -EL_LIM) begin
			el_c = -EL_LIM;
		end else begin
			el_c = el_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= p2_ctl.valid & (mag_unused | ~mag_unused);
		end
	end

	always_ff @(posedge clk) begin
		azimuth   <= az_c[AZ_W-1:0];
		elevation <= el_c[EL_W-1:0];
	end

endmodule
